>>> rtl/core/kmp_prefix_table_core_defines.svh
// assertion macros for the kmp prefix table core
`ifndef KMP_PREFIX_TABLE_CORE_DEFINES_SVH
`define KMP_PREFIX_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// checked at every rising edge outside reset
`define KPT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked at every rising edge outside reset
`define KPT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define KPT_ASSERT(label, clk, rst_n, prop, msg)
`define KPT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/core/kmp_pt_pkg.sv
// constants and types for the kmp prefix table core
package kmp_pt_pkg;

    // pattern capacity in bytes
    localparam int PATTERN_LEN = 16;

    // index into the stores, and a count that can also hold PATTERN_LEN
    localparam int IDX_W = $clog2(PATTERN_LEN);
    localparam int CNT_W = $clog2(PATTERN_LEN + 1);

    // fixed field widths of the input byte and the result beat
    localparam int CHAR_W = 8;
    localparam int POS_W  = 4;
    localparam int BL_W   = 5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

endpackage

>>> rtl/core/kmp_prefix_table_core.sv
// kmp failure table builder: one pattern byte in, one failure entry out
//
//  channel | direction | handshake                      | payload
//  --------+-----------+--------------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall        | i_start_new, i_pattern_char
//  out     | output    | o_out_valid / i_out_stall      | o_position, o_border_len, o_overflow
//
// first byte of a pattern and over-capacity bytes: answered from S_IDLE without a store read
// other bytes: S_READ, S_CMP, then S_READ and S_CMP again per border fallback step (one shared byte compare
//   against the char store, whose read is registered, then a border store lookup)
// fallback steps amortize to under one per byte over a whole pattern
// reset clears sequencer, byte count and running border and stalls the input; stores kept
// a stalled result sits in the output register while the next beat is accepted;
//   a further result then waits in a holding register until the output frees up
`include "kmp_prefix_table_core_defines.svh"

module kmp_prefix_table_core
    import kmp_pt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_start_new,
    input  logic [CHAR_W-1:0]       i_pattern_char,

    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [POS_W-1:0]        o_position,
    output logic signed [BL_W-1:0]  o_border_len,
    output logic                    o_overflow
);

    // sequencer and pattern state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_next_index, n_next_index;
    logic [IDX_W-1:0]   r_running, n_running;

    // working registers of the fallback loop
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_k, n_k;
    logic [CHAR_W-1:0]  r_char, n_char;

    // held result while the output register is busy
    logic [POS_W-1:0]   r_res_pos, n_res_pos;
    logic [BL_W-1:0]    r_res_bl, n_res_bl;
    logic               r_res_ovf, n_res_ovf;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [POS_W-1:0]   r_out_pos, n_out_pos;
    logic [BL_W-1:0]    r_out_bl, n_out_bl;
    logic               r_out_ovf, n_out_ovf;

    // pattern stores, registered reads
    logic [CHAR_W-1:0]  char_mem [PATTERN_LEN];
    logic [IDX_W-1:0]   border_mem [PATTERN_LEN];
    logic [CHAR_W-1:0]  r_rd_char;
    logic [IDX_W-1:0]   r_rd_border;

    // store write port
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [CHAR_W-1:0]  w_wchar;
    logic [IDX_W-1:0]   w_wborder;

    // finishing result of this cycle
    logic               w_fin;
    logic [POS_W-1:0]   w_fin_pos;
    logic [BL_W-1:0]    w_fin_bl;
    logic               w_fin_ovf;

    logic               w_out_free;
    logic               w_match;
    logic [CNT_W-1:0]   w_eff_idx;
    logic [IDX_W-1:0]   w_eff_run;
    logic [IDX_W-1:0]   w_k_fin;

    assign o_in_stall   = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid && i_rst_n;
    assign o_position   = r_out_pos;
    assign o_border_len = r_out_bl;
    assign o_overflow   = r_out_ovf;

    // output register is free now or drains at this edge
    assign w_out_free = !r_out_valid || !i_out_stall;

    // the one shared compare: stored byte at k against the new byte
    assign w_match = (r_rd_char == r_char);

    always_comb begin
        n_state      = r_state;
        n_next_index = r_next_index;
        n_running    = r_running;
        n_idx        = r_idx;
        n_k          = r_k;
        n_char       = r_char;
        n_res_pos    = r_res_pos;
        n_res_bl     = r_res_bl;
        n_res_ovf    = r_res_ovf;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_pos    = r_out_pos;
        n_out_bl     = r_out_bl;
        n_out_ovf    = r_out_ovf;

        w_we         = 1'b0;
        w_waddr      = r_idx;
        w_wchar      = r_char;
        w_wborder    = '0;

        w_fin        = 1'b0;
        w_fin_pos    = '0;
        w_fin_bl     = '0;
        w_fin_ovf    = 1'b0;

        // a start flag restarts the pattern at index 0
        w_eff_idx    = i_start_new ? '0 : r_next_index;
        w_eff_run    = i_start_new ? '0 : r_running;
        w_k_fin      = r_k + IDX_W'(w_match);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_char = i_pattern_char;
                    if (i_start_new) begin
                        n_next_index = '0;
                        n_running    = '0;
                    end
                    if (w_eff_idx >= CNT_W'(PATTERN_LEN)) begin
                        // store full: byte dropped, state kept
                        w_fin     = 1'b1;
                        w_fin_ovf = 1'b1;
                    end else if (w_eff_idx == '0) begin
                        // first byte of a pattern answers -1
                        w_we         = 1'b1;
                        w_waddr      = '0;
                        w_wchar      = i_pattern_char;
                        w_wborder    = '0;
                        n_running    = '0;
                        n_next_index = CNT_W'(1);
                        w_fin        = 1'b1;
                        w_fin_bl     = '1;
                    end else begin
                        n_idx   = IDX_W'(w_eff_idx);
                        n_k     = (CNT_W'(w_eff_run) >= w_eff_idx) ? '0 : w_eff_run;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                // stores are read at k during this cycle
                n_state = S_CMP;
            end
            S_CMP: begin
                if ((r_k != '0) && !w_match) begin
                    // fall back to the border of the prefix of length k
                    n_k     = r_rd_border;
                    n_state = S_READ;
                end else begin
                    w_we         = 1'b1;
                    w_waddr      = r_idx;
                    w_wchar      = r_char;
                    w_wborder    = w_k_fin;
                    n_running    = w_k_fin;
                    n_next_index = CNT_W'(r_idx) + CNT_W'(1);
                    w_fin        = 1'b1;
                    w_fin_pos    = POS_W'(r_idx);
                    w_fin_bl     = BL_W'(w_k_fin);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = r_res_pos;
                    n_out_bl    = r_res_bl;
                    n_out_ovf   = r_res_ovf;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a finished result goes straight out when it can, else it is held
        if (w_fin) begin
            if (w_out_free) begin
                n_out_valid = 1'b1;
                n_out_pos   = w_fin_pos;
                n_out_bl    = w_fin_bl;
                n_out_ovf   = w_fin_ovf;
                n_state     = S_IDLE;
            end else begin
                n_res_pos = w_fin_pos;
                n_res_bl  = w_fin_bl;
                n_res_ovf = w_fin_ovf;
                n_state   = S_DONE;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_next_index <= '0;
            r_running    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_next_index <= n_next_index;
            r_running    <= n_running;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_k       <= n_k;
        r_char    <= n_char;
        r_res_pos <= n_res_pos;
        r_res_bl  <= n_res_bl;
        r_res_ovf <= n_res_ovf;
        r_out_pos <= n_out_pos;
        r_out_bl  <= n_out_bl;
        r_out_ovf <= n_out_ovf;
    end

    // pattern stores: one write port, one read at k and at k-1
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            char_mem[w_waddr]   <= w_wchar;
            border_mem[w_waddr] <= w_wborder;
        end
        r_rd_char   <= char_mem[r_k];
        r_rd_border <= border_mem[r_k - IDX_W'(1)];
    end

    `KPT_ASSERT(a_count_in_range, i_clk, i_rst_n, (r_next_index <= CNT_W'(PATTERN_LEN)), "byte count beyond capacity")
    `KPT_ASSERT_IMP(a_border_below_count, i_clk, i_rst_n, (r_next_index != '0), (CNT_W'(r_running) < r_next_index), "running border not below byte count")
    `KPT_ASSERT_IMP(a_fallback_below_idx, i_clk, i_rst_n, (r_state == S_CMP), (r_k < r_idx), "fallback index reached current byte")
    `KPT_ASSERT_IMP(a_overflow_fields, i_clk, i_rst_n, (r_out_valid && r_out_ovf), ((r_out_pos == '0) && (r_out_bl == '0)), "overflow beat with nonzero fields")

endmodule

>>> bench/kmp_prefix_table_core_test.sv
// self-checking bench for the kmp prefix table core: directed table, then random patterns
`timescale 1ns / 1ps

module kmp_prefix_table_core_test;
    import kmp_pt_pkg::*;

    // ------------------------------------------------------------------
    // types
    // ------------------------------------------------------------------

    // one failure table entry as the output beat carries it
    typedef struct packed {
        logic [POS_W-1:0]       pos;
        logic signed [BL_W-1:0] border;
        logic                   ovf;
    } fail_entry_t;

    // one row of the directed table; the expected entry counts only when typed is set
    typedef struct packed {
        logic                   start;
        logic [CHAR_W-1:0]      ch;
        logic                   typed;
        logic [POS_W-1:0]       pos;
        logic signed [BL_W-1:0] border;
        logic                   ovf;
    } stim_row_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_LIGHT,
        STALL_HEAVY
    } stall_mode_t;

    localparam int DIR_ROWS     = 25;
    localparam int RAND_BYTES   = 1200;
    localparam int QUIET_LIMIT  = 2000;   // cycles with no beat on either side
    localparam int LONG_HOLD    = 300;    // one long receiver hold-off, in cycles
    localparam int HOLD_AT      = 300;    // stored bytes before the long hold-off
    localparam int DRAIN_AT     = 700;    // stored bytes before the sender drains
    localparam int SETTLE       = 40;     // cycles watched after the last result

    // ------------------------------------------------------------------
    // dut signals
    // ------------------------------------------------------------------

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_start_new;
    logic [CHAR_W-1:0]      i_pattern_char;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [POS_W-1:0]       o_position;
    logic signed [BL_W-1:0] o_border_len;
    logic                   o_overflow;

    kmp_prefix_table_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_start_new    (i_start_new),
        .i_pattern_char (i_pattern_char),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_position     (o_position),
        .o_border_len   (o_border_len),
        .o_overflow     (o_overflow)
    );

    // 2 ns period
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // failure table predictor: its own copy of the pattern and entries
    // ------------------------------------------------------------------

    logic [CHAR_W-1:0] pat_bytes   [PATTERN_LEN];
    logic [IDX_W-1:0]  pat_borders [PATTERN_LEN];
    logic [CNT_W-1:0]  byte_count  = '0;
    logic [IDX_W-1:0]  run_border  = '0;

    // expected entries, oldest first
    fail_entry_t pending_entries[$];

    int  mismatches    = 0;
    int  stored_bytes  = 0;    // accepted bytes that were not over capacity
    bit  long_hold     = 1'b0; // receiver is in its long hold-off
    bit  drain_after   = 1'b0; // sender waits for every result after the next beat
    bit  valid_held    = 1'b0; // valid left high after the last accepted beat
    int  burst_left    = 0;

    // computes the entry for one byte and advances the pattern state
    function automatic fail_entry_t next_entry(input logic start, input logic [CHAR_W-1:0] ch);
        fail_entry_t e;
        int          i;
        int          k;
        e = '0;
        if (start) begin
            byte_count = '0;
            run_border = '0;
        end
        // full pattern: byte dropped, state untouched
        if (byte_count >= PATTERN_LEN) begin
            e.ovf = 1'b1;
            return e;
        end
        i = byte_count;
        if (i == 0) begin
            pat_bytes[0]   = ch;
            pat_borders[0] = '0;
            run_border     = '0;
            byte_count     = CNT_W'(1);
            e.border       = -5'sd1;
            return e;
        end
        // border fallback: shrink the candidate border until the next byte extends it
        k = run_border;
        if (k >= i)
            k = 0;
        while (k > 0 && pat_bytes[k] != ch)
            k = pat_borders[k-1];
        if (pat_bytes[k] == ch)
            k++;
        pat_bytes[i]   = ch;
        pat_borders[i] = IDX_W'(k);
        run_border     = IDX_W'(k);
        byte_count     = CNT_W'(i + 1);
        e.pos          = POS_W'(i);
        e.border       = BL_W'(k);
        return e;
    endfunction

    // ------------------------------------------------------------------
    // sender: offers one beat, waits for it to be taken, then idles or not
    // ------------------------------------------------------------------

    task automatic offer_byte(input logic start, input logic [CHAR_W-1:0] ch,
                              input logic typed, input fail_entry_t typed_entry);
        fail_entry_t e;
        i_in_valid     <= 1'b1;
        i_start_new    <= start;
        i_pattern_char <= ch;
        // payload holds until the block takes it
        do
            @(posedge i_clk);
        while (o_in_stall);

        e = next_entry(start, ch);
        if (typed)
            e = typed_entry;
        pending_entries.push_back(e);
        if (!e.ovf)
            stored_bytes++;

        if (drain_after) begin
            // pause until the block has handed back everything
            i_in_valid <= 1'b0;
            valid_held  = 1'b0;
            do
                @(posedge i_clk);
            while (pending_entries.size() != 0);
            drain_after = 1'b0;
            burst_left  = $urandom_range(0, 24);
        end else if (burst_left > 0 || long_hold) begin
            // keep streaming; during the long hold-off this fills the block
            if (burst_left > 0)
                burst_left--;
            valid_held = 1'b1;
        end else begin
            i_in_valid <= 1'b0;
            valid_held  = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(0, 24);
        end
    endtask

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------

    stim_row_t dir_rows [DIR_ROWS] = '{
        // first byte with no start flag after reset
        '{1'b0, 8'h00, 1'b1, 4'd0, -5'sd1, 1'b0},
        // run of equal bytes up to capacity, border climbs to its top
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        // one byte past capacity
        '{1'b0, 8'hFF, 1'b1, 4'd0, 5'sd0, 1'b1},
        // new pattern with a border that has to fall back
        '{1'b1, 8'hFF, 1'b1, 4'd0, -5'sd1, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'hFF, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'h00, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'hFE, 1'b0, 4'd0, 5'sd0, 1'b0},
        '{1'b0, 8'hFF, 1'b0, 4'd0, 5'sd0, 1'b0},
        // start flag in the middle of a pattern
        '{1'b1, 8'h55, 1'b1, 4'd0, -5'sd1, 1'b0},
        '{1'b0, 8'hAA, 1'b0, 4'd0, 5'sd0, 1'b0}
    };

    // ------------------------------------------------------------------
    // main stimulus
    // ------------------------------------------------------------------

    initial begin
        int          kind;
        int          len;
        int          period;
        int          nsym;
        bit          drained_once;
        logic [7:0]  ch;
        logic [7:0]  alpha [3];
        logic [7:0]  base  [6];
        fail_entry_t typed_entry;

        drained_once    = 1'b0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_start_new    <= 1'b0;
        i_pattern_char <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (dir_rows[r]) begin
            typed_entry.pos    = dir_rows[r].pos;
            typed_entry.border = dir_rows[r].border;
            typed_entry.ovf    = dir_rows[r].ovf;
            offer_byte(dir_rows[r].start, dir_rows[r].ch, dir_rows[r].typed, typed_entry);
        end

        // random patterns: mostly well-formed periodic ones with small alphabets,
        // so that long borders and deep fallbacks come up, plus noise
        while (stored_bytes < DIR_ROWS + RAND_BYTES) begin
            if (!drained_once && stored_bytes >= DRAIN_AT) begin
                drain_after  = 1'b1;
                drained_once = 1'b1;
            end
            foreach (alpha[a])
                alpha[a] = 8'($urandom);
            nsym = $urandom_range(1, 3);
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                // periodic pattern, sometimes past capacity, with rare mutations
                len    = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 20)
                                                     : $urandom_range(1, 16);
                period = $urandom_range(1, 6);
                for (int j = 0; j < period; j++)
                    base[j] = alpha[$urandom_range(0, nsym - 1)];
                for (int j = 0; j < len; j++) begin
                    ch = base[j % period];
                    if ($urandom_range(0, 9) == 0)
                        ch = alpha[$urandom_range(0, nsym - 1)];
                    offer_byte(j == 0, ch, 1'b0, '0);
                end
            end else if (kind <= 8) begin
                // noise: any byte, stray start flags
                len = $urandom_range(1, 8);
                for (int j = 0; j < len; j++)
                    offer_byte($urandom_range(0, 7) == 0, 8'($urandom), 1'b0, '0);
            end else begin
                // bytes that carry on whatever pattern is open, without a start
                len = $urandom_range(1, 6);
                for (int j = 0; j < len; j++)
                    offer_byte(1'b0, alpha[$urandom_range(0, 1)], 1'b0, '0);
            end
        end

        if (valid_held)
            i_in_valid <= 1'b0;
        while (pending_entries.size() != 0)
            @(posedge i_clk);
        // catch any stray beat after the last one
        repeat (SETTLE) @(posedge i_clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: stall patterns in segments, and one long hold-off
    // ------------------------------------------------------------------

    initial begin
        stall_mode_t mode;
        int          seg;
        int          period;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold == 1'b0 && stored_bytes >= HOLD_AT && stored_bytes < DRAIN_AT
                    && seg >= 0 && period != -1) begin
                // long hold-off, once; sender keeps streaming so the block backs up
                long_hold = 1'b1;
                repeat (LONG_HOLD) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
                period = -1;
            end
            long_hold = 1'b0;
            mode   = stall_mode_t'($urandom_range(0, 3));
            seg    = $urandom_range(8, 80);
            if (period != -1)
                period = $urandom_range(2, 7);
            for (int c = 0; c < seg; c++) begin
                @(posedge i_clk);
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_COIN:  i_out_stall <= ($urandom_range(0, 1) == 1);
                    STALL_LIGHT: i_out_stall <= ((c % 5) == 0);
                    default:     i_out_stall <= ((c % 4) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // result check: each beat against the oldest expected entry
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        fail_entry_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_entries.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat: position %0d border %0d overflow %0b",
                         $time, o_position, o_border_len, o_overflow);
            end else begin
                want = pending_entries.pop_front();
                if (o_position !== want.pos) begin
                    mismatches++;
                    $display("%0t: position expected %0d got %0d", $time, want.pos, o_position);
                end
                if (o_border_len !== want.border) begin
                    mismatches++;
                    $display("%0t: border expected %0d got %0d", $time, want.border,
                             o_border_len);
                end
                if (o_overflow !== want.ovf) begin
                    mismatches++;
                    $display("%0t: overflow expected %0b got %0b", $time, want.ovf,
                             o_overflow);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with no beat on either side ends the run
    // ------------------------------------------------------------------

    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
